FILE: sv/lz78e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78e_pkg
// Shared types, widths and the microcode table of the LZ78 encoder.
// ----------------------------------------------------------------------------
package lz78e_pkg;

  // Field widths of the stream channels
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PrefixW    = 12;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned OutUserW   = 1;

  // Microcode step index
  localparam int unsigned StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepWait   = 3'd0;
  localparam step_t StepScan   = 3'd1;
  localparam step_t StepBranch = 3'd2;
  localparam step_t StepMiss   = 3'd3;
  localparam step_t StepHit    = 3'd4;
  localparam step_t StepFinal  = 3'd5;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_ACCEPT    = 3'd1,
    COND_SCAN_DONE = 3'd2,
    COND_HIT       = 3'd3,
    COND_OUT_FREE  = 3'd4,
    COND_NOT_LAST  = 3'd5
  } cond_e;

  // Datapath actions
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_LOAD       = 3'd1,
    ACT_SCAN       = 3'd2,
    ACT_EMIT_MISS  = 3'd3,
    ACT_TAKE_HIT   = 3'd4,
    ACT_EMIT_FINAL = 3'd5
  } act_e;

  // One control word
  typedef struct packed {
    logic  in_ready;
    act_e  act;
    cond_e cond;
    logic  hold;
    step_t target;
  } uword_t;

  // Requests to the dictionary memory
  typedef struct packed {
    logic rd;
    logic wr;
  } dict_req_t;

  // Control store: jump to target when the condition holds, else stay
  // (hold) or fall through to the next step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{in_ready: 1'b0, act: ACT_NONE, cond: COND_ALWAYS, hold: 1'b0,
          target: StepWait};
    unique case (s)
      StepWait: begin
        w = '{in_ready: 1'b1, act: ACT_LOAD, cond: COND_ACCEPT, hold: 1'b1,
              target: StepScan};
      end
      StepScan: begin
        w = '{in_ready: 1'b0, act: ACT_SCAN, cond: COND_SCAN_DONE, hold: 1'b1,
              target: StepBranch};
      end
      StepBranch: begin
        w = '{in_ready: 1'b0, act: ACT_NONE, cond: COND_HIT, hold: 1'b0,
              target: StepHit};
      end
      StepMiss: begin
        w = '{in_ready: 1'b0, act: ACT_EMIT_MISS, cond: COND_OUT_FREE, hold: 1'b1,
              target: StepWait};
      end
      StepHit: begin
        w = '{in_ready: 1'b0, act: ACT_TAKE_HIT, cond: COND_NOT_LAST, hold: 1'b0,
              target: StepWait};
      end
      StepFinal: begin
        w = '{in_ready: 1'b0, act: ACT_EMIT_FINAL, cond: COND_OUT_FREE, hold: 1'b1,
              target: StepWait};
      end
      default: begin
        w = '{in_ready: 1'b0, act: ACT_NONE, cond: COND_ALWAYS, hold: 1'b0,
              target: StepWait};
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/lz78e_dict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78e_dict
// Dictionary store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lz78e_dict #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 20
) (
  input  logic                 clk_i,
  input  lz78e_pkg::dict_req_t req_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [DW-1:0]        wr_data_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [DW-1:0]        rd_data_o
);
  import lz78e_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Write a new entry
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/lz78_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_encoder
// LZ78 dictionary compressor driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Search: each accepted byte is matched against the dictionary entries in use
//   (free codes so far, at most DICT_SIZE - 1, none when it is empty), read
//   one entry per cycle through the read port; a hit stops the search early.
// Flow: a new byte is taken only after the last one is fully handled; a
//   stalled result holds the input off until it leaves.
// Reset: step counter, phrase, pending read, hit flag and output valid clear
//   at once and the next free code returns to 1; dictionary contents are
//   not cleared and are only read once written.
// ----------------------------------------------------------------------------
module lz78_encoder #(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lz78e_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tlast,  // final_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lz78e_pkg::OutDataW-1:0] m_axis_tdata,  // [11:0] prefix_code,
                                                        // [19:12] symbol
  output logic [lz78e_pkg::OutUserW-1:0] m_axis_tuser   // [0] symbol_valid
);
  import lz78e_pkg::*;

  localparam int unsigned CW = $clog2(DICT_SIZE);
  localparam int unsigned EW = CW + ByteW;
  localparam logic [CW:0] CodeLimit = (CW+1)'(DICT_SIZE);
  localparam logic [CW:0] CodeOne   = (CW+1)'(1);

  // Sequencer
  step_t  step_q, step_d;
  uword_t uw;
  logic   cond_ok;

  // Datapath registers
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;
  logic [CW-1:0]    phrase_q, phrase_d;
  logic [CW:0]      free_q, free_d;
  logic [CW:0]      k_q, k_d;
  logic             rd_pend_q, rd_pend_d;
  logic [CW-1:0]    rd_addr_q, rd_addr_d;
  logic             hit_q, hit_d;

  // Output register
  logic                   m_valid_q, m_valid_d;
  logic [OutDataW-1:0]    m_data_q, m_data_d;
  logic [OutUserW-1:0]    m_user_q, m_user_d;

  // Dictionary interface
  dict_req_t     dreq;
  logic [EW-1:0] rd_entry;
  logic          s_accept, out_free, match, scan_done, issue, dict_room;
  logic [CW+PrefixW-1:0] prefix_ext;

  assign uw = ucode(step_q);

  assign s_axis_tready = uw.in_ready;
  assign s_accept      = s_axis_tvalid & uw.in_ready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign dict_room     = (free_q < CodeLimit);

  // Compare the entry read last cycle; stop on a hit or when all are read
  assign match     = rd_pend_q & (rd_entry == {phrase_q, byte_q});
  assign scan_done = match | (~rd_pend_q & (k_q >= free_q));
  assign issue     = (uw.act == ACT_SCAN) & ~match & (k_q < free_q);

  // Mask the code to the 12-bit field
  assign prefix_ext = {{PrefixW{1'b0}}, phrase_q};

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_ACCEPT:    cond_ok = s_accept;
      COND_SCAN_DONE: cond_ok = scan_done;
      COND_HIT:       cond_ok = hit_q;
      COND_OUT_FREE:  cond_ok = out_free;
      COND_NOT_LAST:  cond_ok = ~last_q;
      default:        cond_ok = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    if (cond_ok) begin
      step_d = uw.target;
    end else if (uw.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  // Datapath driven by the current control word
  always_comb begin
    byte_d    = byte_q;
    last_d    = last_q;
    phrase_d  = phrase_q;
    free_d    = free_q;
    k_d       = k_q;
    rd_pend_d = 1'b0;
    rd_addr_d = rd_addr_q;
    hit_d     = hit_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    dreq      = '{rd: 1'b0, wr: 1'b0};

    unique case (uw.act)
      ACT_LOAD: begin
        if (s_accept) begin
          byte_d = s_axis_tdata[ByteW-1:0];
          last_d = s_axis_tlast;
          k_d    = CodeOne;
        end
      end
      ACT_SCAN: begin
        if (issue) begin
          dreq.rd   = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = k_q[CW-1:0];
          k_d       = k_q + CodeOne;
        end
        if (scan_done) begin
          hit_d = match;
        end
      end
      ACT_EMIT_MISS: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(OutDataW-PrefixW-ByteW){1'b0}}, byte_q,
                       prefix_ext[PrefixW-1:0]};
          m_user_d  = OutUserW'(1);
          phrase_d  = '0;
          dreq.wr   = dict_room;
          if (last_q) begin
            free_d = CodeOne;
          end else if (dict_room) begin
            free_d = free_q + CodeOne;
          end
        end
      end
      ACT_TAKE_HIT: begin
        phrase_d = rd_addr_q;
      end
      ACT_EMIT_FINAL: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(OutDataW-PrefixW){1'b0}}, prefix_ext[PrefixW-1:0]};
          m_user_d  = '0;
          phrase_d  = '0;
          free_d    = CodeOne;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StepWait;
      phrase_q  <= '0;
      free_q    <= CodeOne;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      phrase_q  <= phrase_d;
      free_q    <= free_d;
      rd_pend_q <= rd_pend_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    last_q    <= last_d;
    k_q       <= k_d;
    rd_addr_q <= rd_addr_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  lz78e_dict #(
    .DEPTH (DICT_SIZE),
    .AW    (CW),
    .DW    (EW)
  ) u_dict (
    .clk_i     (clk_i),
    .req_i     (dreq),
    .wr_addr_i (free_q[CW-1:0]),
    .wr_data_i ({phrase_q, byte_q}),
    .rd_addr_i (k_q[CW-1:0]),
    .rd_data_o (rd_entry)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: sv/lz78e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78e_checker
// Port-level checks of the LZ78 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lz78e_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lz78e_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [lz78e_pkg::OutUserW-1:0] m_axis_tuser
);
  import lz78e_pkg::*;

  // One request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous request in progress");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed or dropped");

  // A phrase sent alone carries a zero symbol
  a_alone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[0] == 1'b0)) |->
      (m_axis_tdata[PrefixW+ByteW-1:PrefixW] == '0))
    else $error("symbol nonzero on a phrase without symbol");

  // Pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:PrefixW+ByteW] == '0))
    else $error("pad bits of result not zero");

endmodule

bind lz78_encoder lz78e_checker u_lz78e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: test/lz78_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_encoder_test
// Self-checking bench for the LZ78 encoder. Byte streams are split into
// messages; a phrase tracker mirrors the dictionary and queues the expected
// (prefix, symbol) tokens, and every token taken from the output stream is
// compared against the oldest one. The dictionary is kept small, at 16 entries,
// so that it fills up within a short message.
// ----------------------------------------------------------------------------
module lz78_encoder_test;

  localparam int unsigned TbDictSize  = 16;
  localparam int unsigned RandomBytes = 108;
  localparam int unsigned HoldOffLen  = 400;
  localparam int unsigned DrainCycles = 60;

  // Expected output token; symbol and prefix packed as on the output stream
  typedef struct packed {
    logic       sym_ok;
    logic [7:0] symbol;
    logic [11:0] prefix;
  } lz78_token_t;

  // Phrase tracker: mirrors phrase, free code and dictionary, queues tokens
  class lz78_token_board;
    int unsigned dict_size;
    int unsigned phrase;
    int unsigned free_code;
    int unsigned ent_prefix[];
    bit [7:0]    ent_byte[];
    lz78_token_t pending_tokens[$];
    int unsigned fails;
    int unsigned tokens_seen;
    int unsigned full_misses;
    int unsigned final_hits;

    function new(int unsigned size);
      dict_size   = size;
      ent_prefix  = new[size];
      ent_byte    = new[size];
      phrase      = 0;
      free_code   = 1;
      fails       = 0;
      tokens_seen = 0;
      full_misses = 0;
      final_hits  = 0;
    endfunction

    function int unsigned pending();
      return pending_tokens.size();
    endfunction

    // Take one accepted byte and queue the token it produces, if any
    function void take_byte(bit [7:0] data, bit last);
      int unsigned hit;
      int unsigned k;
      lz78_token_t tok;
      hit = 0;
      for (k = 1; k < free_code && k < dict_size; k++) begin
        if (hit == 0 && ent_prefix[k] == phrase && ent_byte[k] == data) hit = k;
      end
      if (hit != 0) begin
        phrase = hit;
        // phrase still open at the end of the message goes out alone
        if (last) begin
          tok.prefix = phrase[11:0];
          tok.symbol = 8'h00;
          tok.sym_ok = 1'b0;
          pending_tokens.push_back(tok);
          final_hits++;
        end
      end else begin
        if (free_code < dict_size) begin
          ent_prefix[free_code] = phrase;
          ent_byte[free_code]   = data;
          free_code++;
        end else begin
          full_misses++;
        end
        tok.prefix = phrase[11:0];
        tok.symbol = data;
        tok.sym_ok = 1'b1;
        pending_tokens.push_back(tok);
        phrase = 0;
      end
      // each message starts with an empty dictionary
      if (last) begin
        phrase    = 0;
        free_code = 1;
      end
    endfunction

    // Compare one output token with the oldest expected one
    function void check_token(bit [11:0] prefix, bit [7:0] symbol, bit sym_ok);
      lz78_token_t want;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: prefix_code %0d symbol %0d symbol_valid %0d",
               prefix, symbol, sym_ok);
        fails++;
        return;
      end
      want = pending_tokens.pop_front();
      tokens_seen++;
      if (want.prefix != prefix) begin
        $error("prefix_code mismatch: expected %0d, got %0d", want.prefix, prefix);
        fails++;
      end
      if (want.symbol != symbol) begin
        $error("symbol mismatch: expected %0d, got %0d", want.symbol, symbol);
        fails++;
      end
      if (want.sym_ok != sym_ok) begin
        $error("symbol_valid mismatch: expected %0d, got %0d", want.sym_ok, sym_ok);
        fails++;
      end
    endfunction
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [lz78e_pkg::InDataW-1:0]     s_axis_tdata  = '0;
  logic                              s_axis_tlast  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [lz78e_pkg::OutDataW-1:0]    m_axis_tdata;
  logic [lz78e_pkg::OutUserW-1:0]    m_axis_tuser;

  lz78_token_board board;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holdoff_reqs  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned messages_sent = 0;

  lz78_encoder #(
    .DICT_SIZE(TbDictSize)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Record accepted bytes and check returned tokens
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.take_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_token(m_axis_tdata[11:0], m_axis_tdata[19:12], m_axis_tuser[0]);
      end
    end
  end

  // Drive ready: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned reqs_seen;
    stall_left = 0;
    reqs_seen  = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_reqs != reqs_seen) begin
        reqs_seen  = holdoff_reqs;
        stall_left = HoldOffLen;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input bit [7:0] data, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Send a message, either full-range bytes or a small alphabet that hits often
  task automatic send_message(input int unsigned len, input bit wide);
    bit [7:0]    alpha[4];
    int unsigned n_alpha;
    int unsigned i;
    bit [7:0]    data;
    n_alpha = $urandom_range(4, 1);
    for (i = 0; i < 4; i++) alpha[i] = 8'($urandom);
    for (i = 0; i < len; i++) begin
      data = wide ? 8'($urandom) : alpha[$urandom_range(n_alpha - 1)];
      send_byte(data, i == len - 1);
    end
    messages_sent++;
  endtask

  // Let the monitor note the last accepted request, then wait for its tokens
  task automatic wait_drained();
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    int unsigned i;
    int unsigned rand_base;
    int unsigned phase;
    board = new(TbDictSize);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-byte message, a message that ends on a hit,
    // a message that ends on a miss, and one that overflows the dictionary
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    for (i = 0; i < TbDictSize + 1; i++) send_byte(8'(i * 15), i == TbDictSize);
    messages_sent += 4;

    // Random messages in three idle phases
    rand_base     = bytes_sent;
    phase         = 0;
    send_idle_pct = 38;
    recv_idle_pct = 50;
    while (bytes_sent - rand_base < RandomBytes) begin
      if (phase == 0 && bytes_sent - rand_base >= RandomBytes / 3) begin
        // long receiver hold-off while bytes keep coming
        phase         = 1;
        send_idle_pct = 0;
        holdoff_reqs++;
        send_message(8, 1'b1);
        send_idle_pct = 50;
        recv_idle_pct = 38;
      end else if (phase == 1 && bytes_sent - rand_base >= 2 * RandomBytes / 3) begin
        // pause until the output side has caught up
        phase = 2;
        s_axis_tvalid <= 1'b0;
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_message($urandom_range(24, 1), $urandom_range(3) == 0);
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d bytes in %0d messages, %0d tokens checked;",
             bytes_sent, messages_sent, board.tokens_seen);
    $display("  %0d misses with a full dictionary, %0d messages ending on a hit.",
             board.full_misses, board.final_hits);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
sv/lz78e_pkg.sv
sv/lz78e_dict.sv
sv/lz78_encoder.sv
sv/lz78e_checker.sv
test/lz78_encoder_test.sv
